/* hdl/vlcbp_pkg.sv */
`timescale 1ns / 1ps
// vlcbp_pkg: shared types and constants for the vlc bit packer
// no dependencies

package vlcbp_pkg;

  typedef enum logic [1:0] {
    OP_PUT     = 2'd0,
    OP_FLUSH   = 2'd1,
    OP_DISCARD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PACK,
    S_STUFF
  } state_t;

  localparam logic       REG_ESCAPE    = 1'b0;
  localparam logic       REG_STUFF     = 1'b1;
  localparam logic [7:0] ESCAPE_RESET  = 8'hff;
  localparam logic [7:0] STUFF_RESET   = 8'h00;
  localparam int         MAX_CODE_LEN  = 16;
  localparam int         STREAM_W      = 31;

endpackage

/* hdl/vlc_bit_packer_byte_stuffing.sv */
`timescale 1ns / 1ps
// vlc_bit_packer_byte_stuffing: packs code words and amplitudes into a stuffed byte stream
// depends on vlcbp_pkg
//
// Input channel (in_valid/in_ready) takes one op per beat: put a code word plus
// amplitude, flush the partial byte padded with ones, or discard pending bits.
// Output channel (out_valid/out_ready) gives one byte per beat, MSB first;
// last marks the final byte caused by an input beat. Any data byte equal to the
// escape register is followed by the stuff register byte.
// A put is merged and left aligned into a 31-bit stream register in the accept
// cycle; then one shared byte extractor (a variable left shift of up to eight
// bits) runs once per cycle, each pass emitting one data or stuff byte.
// A put gives up to four data bytes plus stuff bytes; a flush with bits pending
// gives one data byte, followed by a stuff byte if it equals the escape register;
// a discard gives none. in_ready is low while the extractor runs. The output
// register lets the next item be accepted while the last byte of the previous
// one still waits. When the receiver stalls the extractor holds. Reset clears
// pending bits and the output valid flag and loads the escape and stuff
// registers with 0xff and 0x00. Config writes take effect at once.

module vlc_bit_packer_byte_stuffing (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [15:0] code_word,
  input  logic [4:0]  code_length,
  input  logic [3:0]  amplitude_bits,
  input  logic signed [15:0] amplitude,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW = vlcbp_pkg::STREAM_W;

  vlcbp_pkg::state_t state, state_next;

  logic [7:0]    escape_byte;
  logic [7:0]    stuff_byte;
  logic [2:0]    pend_cnt;
  logic [7:0]    pend_byte;
  logic [SW-1:0] stream;
  logic [4:0]    rem;

  // put merge
  logic [4:0]    len_c;
  logic [16:0]   code_mask;
  logic [15:0]   code_m;
  logic [15:0]   amp_adj;
  logic [15:0]   amp_mask;
  logic [15:0]   amp_m;
  logic [SW-1:0] merged;
  logic [4:0]    nbits;
  logic [SW-1:0] load_stream;

  // byte extractor
  logic [5:0]    avail;
  logic [7:0]    cur_byte;
  logic [3:0]    step;
  logic [SW-1:0] sh_stream;
  logic [4:0]    rem_after;
  logic          is_esc;
  logic          slot_free;
  logic          accept;
  logic          emit_data;
  logic          emit_stuff;

  assign in_ready  = (state == vlcbp_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    len_c     = (code_length > 5'(vlcbp_pkg::MAX_CODE_LEN)) ?
                5'(vlcbp_pkg::MAX_CODE_LEN) : code_length;
    code_mask = (17'd1 << len_c) - 17'd1;
    code_m    = code_word & code_mask[15:0];
    amp_adj   = amplitude[15] ? (16'(amplitude) - 16'd1) : 16'(amplitude);
    amp_mask  = (16'd1 << amplitude_bits) - 16'd1;
    amp_m     = amp_adj & amp_mask;
    merged    = ({15'b0, code_m} << amplitude_bits) | {15'b0, amp_m};
    nbits     = len_c + {1'b0, amplitude_bits};
    load_stream = merged << (5'(SW) - nbits);
  end

  always_comb begin
    avail     = {3'b0, pend_cnt} + {1'b0, rem};
    cur_byte  = pend_byte | (stream[SW-1:SW-8] >> pend_cnt);
    step      = 4'd8 - {1'b0, pend_cnt};
    sh_stream = stream << step;
    rem_after = rem - {1'b0, step};
    is_esc    = (cur_byte == escape_byte);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      vlcbp_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == vlcbp_pkg::OP_PUT) begin
            state_next = vlcbp_pkg::S_PACK;
          end else if (op == vlcbp_pkg::OP_FLUSH && pend_cnt != 3'd0) begin
            state_next = vlcbp_pkg::S_PACK;
          end
        end
      end
      vlcbp_pkg::S_PACK: begin
        if (avail < 6'd8) begin
          state_next = vlcbp_pkg::S_IDLE;
        end else if (slot_free) begin
          if (is_esc) begin
            state_next = vlcbp_pkg::S_STUFF;
          end else if (rem_after < 5'd8) begin
            state_next = vlcbp_pkg::S_IDLE;
          end else begin
            state_next = vlcbp_pkg::S_PACK;
          end
        end
      end
      vlcbp_pkg::S_STUFF: begin
        if (slot_free) begin
          state_next = (rem < 5'd8) ? vlcbp_pkg::S_IDLE : vlcbp_pkg::S_PACK;
        end
      end
      default: state_next = vlcbp_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    emit_data  = 1'b0;
    emit_stuff = 1'b0;
    unique case (state)
      vlcbp_pkg::S_IDLE:  ;
      vlcbp_pkg::S_PACK:  emit_data  = (avail >= 6'd8) && slot_free;
      vlcbp_pkg::S_STUFF: emit_stuff = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= vlcbp_pkg::S_IDLE;
      escape_byte <= vlcbp_pkg::ESCAPE_RESET;
      stuff_byte  <= vlcbp_pkg::STUFF_RESET;
      pend_cnt    <= 3'd0;
      pend_byte   <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == vlcbp_pkg::REG_ESCAPE) begin
          escape_byte <= cfg_data;
        end else begin
          stuff_byte <= cfg_data;
        end
      end

      if (accept && op == vlcbp_pkg::OP_DISCARD) begin
        pend_cnt  <= 3'd0;
        pend_byte <= 8'd0;
      end else if (state == vlcbp_pkg::S_PACK && avail < 6'd8) begin
        // not enough for a byte: the new bits join the pending byte
        pend_cnt  <= avail[2:0];
        pend_byte <= cur_byte;
      end else if (emit_data) begin
        if (!is_esc && rem_after < 5'd8) begin
          pend_cnt  <= rem_after[2:0];
          pend_byte <= sh_stream[SW-1:SW-8];
        end else begin
          pend_cnt  <= 3'd0;
          pend_byte <= 8'd0;
        end
      end else if (emit_stuff && rem < 5'd8) begin
        pend_cnt  <= rem[2:0];
        pend_byte <= stream[SW-1:SW-8];
      end

      if (emit_data || emit_stuff) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && op == vlcbp_pkg::OP_PUT) begin
      stream <= load_stream;
      rem    <= nbits;
    end else if (accept && op == vlcbp_pkg::OP_FLUSH) begin
      // ones in the free low bits of the partial byte
      stream <= {8'hff << pend_cnt, {(SW-8){1'b0}}};
      rem    <= 5'd8 - {2'b0, pend_cnt};
    end else if (emit_data) begin
      stream <= sh_stream;
      rem    <= rem_after;
    end

    if (emit_data) begin
      out_byte <= cur_byte;
      last     <= !is_esc && (rem_after < 5'd8);
    end else if (emit_stuff) begin
      out_byte <= stuff_byte;
      last     <= (rem < 5'd8);
    end
  end

`ifndef SYNTH
  // unused low bits of the pending byte are always zero
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pend_byte & (8'hff >> pend_cnt)) == 8'd0)
    else $error("pending byte has bits below its count");

  // a stuff beat always follows a data beat still held in the output register
  a_stuff_held: assert property (@(posedge clk) disable iff (rst)
    state == vlcbp_pkg::S_STUFF |-> out_valid)
    else $error("stuff state without a data beat in the output register");

  // stream bits past the remaining count are zero while the extractor runs
  a_stream_clean: assert property (@(posedge clk) disable iff (rst)
    state != vlcbp_pkg::S_IDLE |-> (stream & ({SW{1'b1}} >> rem)) == '0)
    else $error("stream holds bits past its remaining count");

  // an escape byte leaves the extractor in the stuff state
  a_esc_stuff: assert property (@(posedge clk) disable iff (rst)
    emit_data && is_esc |=> state == vlcbp_pkg::S_STUFF)
    else $error("escape byte not followed by stuff state");
`endif

endmodule

/* verif/tb_vlc_bit_packer_byte_stuffing.sv */
`timescale 1ns / 1ps
// tb_vlc_bit_packer_byte_stuffing: self-checking bench for the vlc bit packer
// predicts the packed, stuffed byte stream of each accepted beat and checks it in order
// depends on vlcbp_pkg and vlc_bit_packer_byte_stuffing

module tb_vlc_bit_packer_byte_stuffing;

  // idle wait after draining, so that items without output bytes have finished
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] data;
    logic       is_last;
  } stream_beat_t;

  class byte_stream_scoreboard;
    logic [7:0]   escape_val = vlcbp_pkg::ESCAPE_RESET;
    logic [7:0]   stuff_val  = vlcbp_pkg::STUFF_RESET;
    int unsigned  held_bits  = 0;
    logic [7:0]   held_byte  = 8'h00;
    stream_beat_t bytes_due[$];
    int unsigned  mismatches = 0;

    function void load_register(logic idx, logic [7:0] val);
      if (idx == vlcbp_pkg::REG_ESCAPE) escape_val = val;
      else stuff_val = val;
    endfunction

    function int unsigned outstanding();
      return bytes_due.size();
    endfunction

    function void push_byte(logic [7:0] b);
      bytes_due.push_back('{data: b, is_last: 1'b0});
      if (b == escape_val) bytes_due.push_back('{data: stuff_val, is_last: 1'b0});
    endfunction

    // bit-exact packing of one accepted input beat
    function void pack_item(vlcbp_pkg::op_t o, logic [15:0] cw, logic [4:0] len,
                            logic [3:0] ab, logic [15:0] amp);
      int unsigned  code_len;
      int unsigned  total;
      int unsigned  start;
      logic [15:0]  amp_adj;
      logic [63:0]  acc;
      stream_beat_t tail;
      start = bytes_due.size();
      case (o)
        vlcbp_pkg::OP_PUT: begin
          code_len = (len > vlcbp_pkg::MAX_CODE_LEN) ? vlcbp_pkg::MAX_CODE_LEN : len;
          // negative amplitudes go out as value minus one
          amp_adj = amp[15] ? amp - 16'd1 : amp;
          acc = (held_bits > 0) ? 64'(held_byte >> (8 - held_bits)) : 64'd0;
          acc = (acc << code_len) | (64'(cw) & ((64'd1 << code_len) - 64'd1));
          acc = (acc << ab) | (64'(amp_adj) & ((64'd1 << ab) - 64'd1));
          total = held_bits + code_len + ab;
          while (total >= 8) begin
            push_byte(8'(acc >> (total - 8)));
            total -= 8;
            acc &= (64'd1 << total) - 64'd1;
          end
          held_bits = total;
          held_byte = (total > 0) ? 8'(acc << (8 - total)) : 8'h00;
        end
        vlcbp_pkg::OP_FLUSH: begin
          if (held_bits > 0) begin
            push_byte(held_byte | 8'((32'd1 << (8 - held_bits)) - 32'd1));
            held_bits = 0;
            held_byte = 8'h00;
          end
        end
        vlcbp_pkg::OP_DISCARD: begin
          held_bits = 0;
          held_byte = 8'h00;
        end
        default: ;
      endcase
      if (bytes_due.size() > start) begin
        tail = bytes_due.pop_back();
        tail.is_last = 1'b1;
        bytes_due.push_back(tail);
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task match_byte(logic [7:0] got_byte, logic got_last);
      stream_beat_t due;
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("byte %02h arrived with nothing due", got_byte));
      end else begin
        due = bytes_due.pop_front();
        if (got_byte !== due.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, due.data));
        if (got_last !== due.is_last)
          report_mismatch($sformatf("last %b on byte %02h, want %b", got_last, got_byte,
                                    due.is_last));
      end
    endtask
  endclass

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  vlcbp_pkg::op_t     op             = vlcbp_pkg::OP_PUT;
  logic [15:0]        code_word      = 16'h0000;
  logic [4:0]         code_length    = 5'd0;
  logic [3:0]         amplitude_bits = 4'd0;
  logic signed [15:0] amplitude      = 16'sd0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [7:0]         out_byte;
  logic               last;
  logic               cfg_we         = 1'b0;
  logic               cfg_index      = vlcbp_pkg::REG_ESCAPE;
  logic [7:0]         cfg_data       = 8'h00;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  byte_stream_scoreboard sb = new();

  vlc_bit_packer_byte_stuffing dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .code_word      (code_word),
    .code_length    (code_length),
    .amplitude_bits (amplitude_bits),
    .amplitude      (amplitude),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last           (last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  // bytes leaving this edge belong to earlier beats, so check before noting the new one
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.match_byte(out_byte, last);
      if (in_valid && in_ready)
        sb.pack_item(op, code_word, code_length, amplitude_bits, amplitude);
    end
  end

  task automatic send_item(vlcbp_pkg::op_t o, logic [15:0] cw, logic [4:0] len,
                           logic [3:0] ab, logic [15:0] amp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op             = o;
    code_word      = cw;
    code_length    = len;
    amplitude_bits = ab;
    amplitude      = amp;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_input();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic set_register(logic idx, logic [7:0] val);
    drain_input();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.load_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_items(int unsigned count);
    int unsigned    sent;
    int unsigned    pick;
    vlcbp_pkg::op_t o;
    logic [15:0]    cw;
    logic [4:0]     len;
    logic [15:0]    amp;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 76) o = vlcbp_pkg::OP_PUT;
      else if (pick < 88) o = vlcbp_pkg::OP_FLUSH;
      else if (pick < 95) o = vlcbp_pkg::OP_DISCARD;
      else o = vlcbp_pkg::OP_NONE;
      pick = $urandom_range(19);
      if (pick == 0) len = 5'd0;
      else if (pick < 18) len = 5'($urandom_range(16, 1));
      else len = 5'($urandom_range(31, 17));
      // all-ones codes make escape bytes show up often
      cw  = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
      amp = ($urandom_range(3) == 0) ? 16'($urandom_range(16)) - 16'd8 : 16'($urandom);
      send_item(o, cw, len, 4'($urandom_range(15)), amp);
      sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    idle_pct  = 18;
    stall_pct = 61;

    // directed corners under reset register values
    send_item(vlcbp_pkg::OP_PUT, 16'h00ff, 5'd8, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'hffff, 5'd16, 4'd15, 16'h7fff);
    send_item(vlcbp_pkg::OP_PUT, 16'hffff, 5'd31, 4'd15, 16'h8001);
    send_item(vlcbp_pkg::OP_PUT, 16'hffff, 5'd3, 4'd4, 16'h7fff);
    send_item(vlcbp_pkg::OP_PUT, 16'h0000, 5'd0, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'h0005, 5'd3, 4'd0, 16'hffff);
    send_item(vlcbp_pkg::OP_PUT, 16'h0000, 5'd1, 4'd15, 16'hffff);
    send_item(vlcbp_pkg::OP_PUT, 16'h0000, 5'd0, 4'd15, 16'h8000);
    send_item(vlcbp_pkg::OP_FLUSH, 16'h1234, 5'd9, 4'd3, 16'h0042);
    send_item(vlcbp_pkg::OP_FLUSH, 16'h0000, 5'd0, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'h0001, 5'd5, 4'd2, 16'h0001);
    send_item(vlcbp_pkg::OP_DISCARD, 16'hffff, 5'd31, 4'd15, 16'hffff);
    send_item(vlcbp_pkg::OP_NONE, 16'hffff, 5'd31, 4'd15, 16'h8000);
    send_item(vlcbp_pkg::OP_FLUSH, 16'hffff, 5'd16, 4'd15, 16'h7fff);
    send_item(vlcbp_pkg::OP_PUT, 16'h007f, 5'd7, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_FLUSH, 16'h0000, 5'd0, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'h0000, 5'd7, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_FLUSH, 16'h0000, 5'd0, 4'd0, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'h0000, 5'd16, 4'd15, 16'h0000);
    send_item(vlcbp_pkg::OP_PUT, 16'hffff, 5'd16, 4'd1, 16'h0001);
    send_item(vlcbp_pkg::OP_FLUSH, 16'h0000, 5'd0, 4'd0, 16'h0000);

    set_register(vlcbp_pkg::REG_ESCAPE, 8'h00);
    set_register(vlcbp_pkg::REG_STUFF, 8'hff);
    random_items(46);
    set_register(vlcbp_pkg::REG_ESCAPE, 8'hff);
    set_register(vlcbp_pkg::REG_STUFF, 8'h00);
    random_items(49);

    idle_pct  = 61;
    stall_pct = 18;
    // stuff equal to escape must not stuff again
    set_register(vlcbp_pkg::REG_ESCAPE, 8'ha5);
    set_register(vlcbp_pkg::REG_STUFF, 8'ha5);
    random_items(24);
    drain_input();
    random_items(24);
    set_register(vlcbp_pkg::REG_ESCAPE, 8'($urandom));
    set_register(vlcbp_pkg::REG_STUFF, 8'($urandom));
    random_items(49);

    idle_pct  = 0;
    stall_pct = 0;
    set_register(vlcbp_pkg::REG_ESCAPE, 8'hff);
    set_register(vlcbp_pkg::REG_STUFF, 8'hff);
    random_items(49);
    set_register(vlcbp_pkg::REG_ESCAPE, 8'($urandom));
    set_register(vlcbp_pkg::REG_STUFF, 8'($urandom));
    random_items(48);

    drain_input();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
